// ===== sv/indexed_vector_store_defines.svh =====
// assertion macros for the indexed vector store checker
// depends on nothing; expects aclk and aresetn in the including scope
`ifndef INDEXED_VECTOR_STORE_DEFINES_SVH
`define INDEXED_VECTOR_STORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define IVS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ivs check failed");

// next-cycle implication, disabled during reset
`define IVS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ivs check failed");

`endif

// ===== sv/ivs_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, codes and controller/datapath interface types
// depends on nothing
package ivs_pkg;

    localparam int DEPTH        = 64;
    localparam int ADDR_W       = $clog2(DEPTH);
    localparam int COUNT_W      = $clog2(DEPTH + 1);
    localparam int OP_W         = 3;
    localparam int INDEX_W      = 6;
    localparam int VALUE_W      = 32;
    localparam int ITEM_COUNT_W = 7;
    localparam int STATUS_W     = 2;

    localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
    localparam logic [OP_W-1:0] OP_POP    = 3'd1;
    localparam logic [OP_W-1:0] OP_READ   = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic shift_step;
        logic load_result;
    } ivs_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic start_shift;
        logic shift_more;
        logic result_pending;
    } ivs_sts_t;

endpackage

// ===== sv/ivs_ram.sv =====
`timescale 1ns / 1ps
// generic simple dual-port ram, one write and one registered read port
// depends on nothing
module ivs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/ivs_ctrl.sv =====
`timescale 1ns / 1ps
// controller state machine for the indexed vector store
// depends on ivs_pkg
module ivs_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ivs_pkg::ivs_sts_t sts,
    output ivs_pkg::ivs_cmd_t cmd
);
    import ivs_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_SHIFT  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       slot_free;

    // result register empty or being drained this cycle
    assign slot_free = !sts.result_pending;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = sts.start_shift ? S_SHIFT : S_FINISH;
            end
            S_SHIFT: begin
                cmd.shift_step = 1'b1;
                if (!sts.shift_more) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                s_ready         = slot_free;
                cmd.load_result = slot_free;
                cmd.capture     = slot_free && s_valid;
                if (slot_free) begin
                    state_next = s_valid ? S_EXEC : S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/ivs_datapath.sv =====
`timescale 1ns / 1ps
// datapath: request latch, word count, shift pointer, word ram and result register
// depends on ivs_pkg and ivs_ram
module ivs_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  ivs_pkg::ivs_cmd_t                    cmd,
    output ivs_pkg::ivs_sts_t                    sts,
    input  logic [ivs_pkg::OP_W-1:0]             s_op,
    input  logic [ivs_pkg::INDEX_W-1:0]          s_index,
    input  logic signed [ivs_pkg::VALUE_W-1:0]   s_value,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [ivs_pkg::VALUE_W-1:0]   m_read_value,
    output logic [ivs_pkg::ITEM_COUNT_W-1:0]     m_item_count,
    output logic [ivs_pkg::STATUS_W-1:0]         m_status
);
    import ivs_pkg::*;

    // request latch
    logic [OP_W-1:0]    op_reg;
    logic [INDEX_W-1:0] idx_reg;
    logic [VALUE_W-1:0] val_reg;

    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0]   ptr_reg, ptr_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                use_rd_reg, use_rd_next;

    logic                m_valid_reg, m_valid_next;
    logic [VALUE_W-1:0]  m_read_value_reg;
    logic [COUNT_W-1:0]  m_item_count_reg;
    logic [STATUS_W-1:0] m_status_reg;

    // ram ports
    logic               we, re;
    logic [ADDR_W-1:0]  waddr, raddr;
    logic [VALUE_W-1:0] wdata, rdata;

    logic [COUNT_W-1:0] idx_ext;
    logic [COUNT_W-1:0] idx_plus1;
    logic [COUNT_W-1:0] ptr_plus1;
    logic               idx_in_range;

    assign idx_ext      = COUNT_W'(idx_reg);
    assign idx_plus1    = idx_ext + COUNT_W'(1);
    assign ptr_plus1    = COUNT_W'(ptr_reg) + COUNT_W'(1);
    assign idx_in_range = idx_ext < count_reg;

    assign sts.start_shift    = cmd.exec && (op_reg == OP_REMOVE) && idx_in_range
                                && (idx_plus1 != count_reg);
    assign sts.shift_more     = ptr_plus1 < count_reg;
    assign sts.result_pending = m_valid_reg && !m_ready;

    always_comb begin
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        status_next = status_reg;
        use_rd_next = use_rd_reg;
        we          = 1'b0;
        waddr       = ADDR_W'(count_reg);
        wdata       = val_reg;
        re          = 1'b0;
        raddr       = ADDR_W'(idx_reg);
        if (cmd.exec) begin
            status_next = ST_OK;
            use_rd_next = 1'b0;
            unique case (op_reg)
                OP_PUSH: begin
                    if (count_reg == COUNT_W'(DEPTH)) begin
                        status_next = ST_FULL;
                    end else begin
                        we         = 1'b1;
                        count_next = count_reg + COUNT_W'(1);
                    end
                end
                OP_POP: begin
                    if (count_reg == '0) begin
                        status_next = ST_RANGE;
                    end else begin
                        count_next  = count_reg - COUNT_W'(1);
                        re          = 1'b1;
                        raddr       = ADDR_W'(count_reg - COUNT_W'(1));
                        use_rd_next = 1'b1;
                    end
                end
                OP_READ: begin
                    if (!idx_in_range) begin
                        status_next = ST_RANGE;
                    end else begin
                        re          = 1'b1;
                        use_rd_next = 1'b1;
                    end
                end
                OP_REMOVE: begin
                    if (!idx_in_range) begin
                        status_next = ST_RANGE;
                    end else if (idx_plus1 == count_reg) begin
                        count_next = count_reg - COUNT_W'(1);
                    end else begin
                        // prime the read of the first word that moves down
                        re       = 1'b1;
                        raddr    = ADDR_W'(idx_plus1);
                        ptr_next = ADDR_W'(idx_plus1);
                    end
                end
                OP_CLEAR: begin
                    count_next = '0;
                end
                default: begin
                end
            endcase
        end else if (cmd.shift_step) begin
            // word at ptr sits on the read port; drop it one place lower
            we    = 1'b1;
            waddr = ptr_reg - ADDR_W'(1);
            wdata = rdata;
            if (sts.shift_more) begin
                re       = 1'b1;
                raddr    = ADDR_W'(ptr_plus1);
                ptr_next = ADDR_W'(ptr_plus1);
            end else begin
                count_next = count_reg - COUNT_W'(1);
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_result) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg     <= ptr_next;
        status_reg  <= status_next;
        use_rd_reg  <= use_rd_next;
        if (cmd.capture) begin
            op_reg  <= s_op;
            idx_reg <= s_index;
            val_reg <= s_value;
        end
        if (cmd.load_result) begin
            m_read_value_reg <= use_rd_reg ? rdata : '0;
            m_item_count_reg <= count_reg;
            m_status_reg     <= status_reg;
        end
    end

    ivs_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign m_valid      = m_valid_reg;
    assign m_read_value = m_read_value_reg;
    assign m_item_count = ITEM_COUNT_W'(m_item_count_reg);
    assign m_status     = m_status_reg;

endmodule

// ===== sv/indexed_vector_store.sv =====
`timescale 1ns / 1ps
// top level of the indexed vector store: controller plus datapath
// depends on ivs_pkg, ivs_ctrl, ivs_datapath (and ivs_ram below it)
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------
//  request  | s_valid / s_ready  | s_op[2:0], s_index[5:0], s_value[31:0]
//  result   | m_valid / m_ready  | m_read_value[31:0], m_item_count[6:0],
//           |                    | m_status[1:0]
//
// push, pop, read, clear: execute step, then finish step, which takes the next request
// remove at index i of n words: the n - 1 - i words above i move down, one word per cycle
//   through the single write and registered read port of the word ram
// reset clears the controller state, the word count and the result valid flag only; no ram sweep
// a held result stalls the block in its finish step; the next request is taken
//   in the same cycle the held result drains
module indexed_vector_store (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // request channel
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [ivs_pkg::OP_W-1:0]             s_op,
    input  logic [ivs_pkg::INDEX_W-1:0]          s_index,
    input  logic signed [ivs_pkg::VALUE_W-1:0]   s_value,
    // result channel
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [ivs_pkg::VALUE_W-1:0]   m_read_value,
    output logic [ivs_pkg::ITEM_COUNT_W-1:0]     m_item_count,
    output logic [ivs_pkg::STATUS_W-1:0]         m_status
);
    import ivs_pkg::*;

    // command and status between the state machine and the datapath
    ivs_cmd_t cmd;
    ivs_sts_t sts;

    // sequencing: idle, execute, shift loop for remove, finish
    ivs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // storage, count and the output register
    ivs_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .s_op         (s_op),
        .s_index      (s_index),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_value (m_read_value),
        .m_item_count (m_item_count),
        .m_status     (m_status)
    );

endmodule

// ===== sv/ivs_checker.sv =====
`timescale 1ns / 1ps
// port-level checks for the indexed vector store, bound to the top level
// depends on ivs_pkg and indexed_vector_store_defines.svh
`include "indexed_vector_store_defines.svh"

module ivs_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_valid,
    input logic                                 s_ready,
    input logic [ivs_pkg::OP_W-1:0]             s_op,
    input logic [ivs_pkg::INDEX_W-1:0]          s_index,
    input logic signed [ivs_pkg::VALUE_W-1:0]   s_value,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic signed [ivs_pkg::VALUE_W-1:0]   m_read_value,
    input logic [ivs_pkg::ITEM_COUNT_W-1:0]     m_item_count,
    input logic [ivs_pkg::STATUS_W-1:0]         m_status
);
    import ivs_pkg::*;

    logic m_stall;
    logic s_wait;
    logic s_xfer;
    logic [VALUE_W+ITEM_COUNT_W+STATUS_W-1:0] m_payload;
    logic [OP_W+INDEX_W+VALUE_W-1:0]          s_payload;

    assign m_stall   = m_valid && !m_ready;
    assign s_wait    = s_valid && !s_ready;
    assign s_xfer    = s_valid && s_ready;
    assign m_payload = {m_read_value, m_item_count, m_status};
    assign s_payload = {s_op, s_index, s_value};

    // a stalled result holds
    `IVS_ASSERT_NEXT(a_result_hold, m_stall, m_valid && $stable(m_payload))
    // a waiting request holds
    `IVS_ASSERT_NEXT(a_request_hold, s_wait, s_valid && $stable(s_payload))
    // store full only reported with every slot in use
    `IVS_ASSERT_NOW(a_full_count, m_valid && (m_status == ST_FULL), m_item_count == ITEM_COUNT_W'(DEPTH))
    // range errors never carry data
    `IVS_ASSERT_NOW(a_range_zero, m_valid && (m_status == ST_RANGE), m_read_value == '0)
    // one request in flight: no transfer in the cycle after a transfer
    `IVS_ASSERT_NEXT(a_one_in_flight, s_xfer, !s_ready)

endmodule

bind indexed_vector_store ivs_checker u_ivs_checker (.*);

// ===== tb/sv/ivs_tb_pkg.sv =====
`timescale 1ns / 1ps
// result prediction and checking for the indexed vector store testbench
// depends on ivs_pkg for widths, depth, op and status codes
package ivs_tb_pkg;

    import ivs_pkg::*;

    // op codes the block must treat as no-ops
    localparam logic [OP_W-1:0] OP_UNUSED_A = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_B = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_C = 3'd7;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  read_value;
        logic [ITEM_COUNT_W-1:0]    item_count;
        logic [STATUS_W-1:0]        status;
    } store_result_t;

    class store_result_checker;

        // shadow copy of the vector contents
        logic signed [VALUE_W-1:0] shadow_words [DEPTH];
        int shadow_fill;
        store_result_t awaited_results [$];

        int errors;
        int requests_seen;
        int results_checked;
        int full_pushes;
        int empty_pops;
        int range_misses;
        int shifting_removes;
        int unused_ops;
        int peak_fill;

        function new();
            shadow_fill = 0;
            errors = 0;
            requests_seen = 0;
            results_checked = 0;
            full_pushes = 0;
            empty_pops = 0;
            range_misses = 0;
            shifting_removes = 0;
            unused_ops = 0;
            peak_fill = 0;
        endfunction

        // work out the result of an accepted request and queue it
        function void note_request(logic [OP_W-1:0] op, logic [INDEX_W-1:0] idx,
                                   logic signed [VALUE_W-1:0] word);
            store_result_t r;
            int pos;
            pos = int'(idx);
            r.read_value = '0;
            r.status = ST_OK;
            requests_seen++;
            case (op)
                OP_PUSH: begin
                    if (shadow_fill >= DEPTH) begin
                        r.status = ST_FULL;
                        full_pushes++;
                    end else begin
                        shadow_words[shadow_fill] = word;
                        shadow_fill++;
                    end
                end
                OP_POP: begin
                    if (shadow_fill == 0) begin
                        r.status = ST_RANGE;
                        empty_pops++;
                    end else begin
                        shadow_fill--;
                        r.read_value = shadow_words[shadow_fill];
                    end
                end
                OP_READ: begin
                    if (pos >= shadow_fill) begin
                        r.status = ST_RANGE;
                        range_misses++;
                    end else begin
                        r.read_value = shadow_words[pos];
                    end
                end
                OP_REMOVE: begin
                    if (pos >= shadow_fill) begin
                        r.status = ST_RANGE;
                        range_misses++;
                    end else begin
                        if (pos < shadow_fill - 1)
                            shifting_removes++;
                        for (int k = pos; k + 1 < shadow_fill; k++)
                            shadow_words[k] = shadow_words[k + 1];
                        shadow_fill--;
                    end
                end
                OP_CLEAR: begin
                    shadow_fill = 0;
                end
                default: begin
                    unused_ops++;
                end
            endcase
            if (shadow_fill > peak_fill)
                peak_fill = shadow_fill;
            r.item_count = shadow_fill[ITEM_COUNT_W-1:0];
            awaited_results = {awaited_results, r};
        endfunction

        // compare one result transfer with the oldest prediction
        function void check_result(logic signed [VALUE_W-1:0] read_value,
                                   logic [ITEM_COUNT_W-1:0] item_count,
                                   logic [STATUS_W-1:0] status);
            store_result_t exp_r;
            if (awaited_results.size() == 0) begin
                $error("result transfer with no request outstanding");
                errors++;
                return;
            end
            exp_r = awaited_results.pop_front();
            results_checked++;
            if (read_value !== exp_r.read_value) begin
                $error("read_value: expected %0d, got %0d", exp_r.read_value, read_value);
                errors++;
            end
            if (item_count !== exp_r.item_count) begin
                $error("item_count: expected %0d, got %0d", exp_r.item_count, item_count);
                errors++;
            end
            if (status !== exp_r.status) begin
                $error("status: expected %0d, got %0d", exp_r.status, status);
                errors++;
            end
        endfunction

    endclass

endpackage

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// top of the indexed vector store testbench: clock, reset, request driver,
// result sink with its own stall pattern, watchdog; depends on ivs_pkg and ivs_tb_pkg
module tb_top;

    import ivs_pkg::*;
    import ivs_tb_pkg::*;

    localparam int RANDOM_REQUESTS = 550;
    localparam int WATCHDOG_LIMIT  = 4000;
    // a remove at the front of a full store walks every word above it once
    localparam int SETTLE_CYCLES   = 2 * DEPTH;

    typedef enum logic [1:0] {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIX
    } traffic_mode_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    // every input known from time zero
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [OP_W-1:0]           s_op = OP_PUSH;
    logic [INDEX_W-1:0]        s_index = '0;
    logic signed [VALUE_W-1:0] s_value = '0;

    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic signed [VALUE_W-1:0]  m_read_value;
    logic [ITEM_COUNT_W-1:0]    m_item_count;
    logic [STATUS_W-1:0]        m_status;

    store_result_checker store = new();

    // receiver stall pattern state
    logic [15:0] ready_pattern = 16'hffff;
    int          ready_mode = 0;
    int          ready_phase_left = 0;

    int idle_cycles = 0;

    always #5 aclk = ~aclk;

    indexed_vector_store DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_index      (s_index),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_value (m_read_value),
        .m_item_count (m_item_count),
        .m_status     (m_status)
    );

    // result side: check every transfer against the oldest prediction, then
    // choose the next ready level; modes are drawn at random among never stalling, a
    // weighted coin flip per cycle and a rotating 16-bit pattern
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            store.check_result(m_read_value, m_item_count, m_status);

        if (ready_phase_left == 0) begin
            ready_mode = $urandom_range(2, 0);
            ready_phase_left = $urandom_range(120, 20);
            ready_pattern = 16'($urandom_range(16'hffff, 0));
            // never a pattern that stalls for good
            if (ready_pattern == '0)
                ready_pattern = 16'h0001;
        end else begin
            ready_phase_left--;
        end

        case (ready_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(99, 0) < 70);
            default: begin
                m_ready <= ready_pattern[0];
                ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
            end
        endcase
    end

    // watchdog: too long without a transfer on either channel ends the run
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     idle_cycles, store.awaited_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // present one request and hold it until the transfer; valid stays high
    // into the next request unless a gap follows
    task automatic send_request(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx,
                                input logic signed [VALUE_W-1:0] word);
        s_valid <= 1'b1;
        s_op    <= op;
        s_index <= idx;
        s_value <= word;
        do @(posedge aclk); while (!s_ready);
        store.note_request(op, idx, word);
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            s_valid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    function automatic logic signed [VALUE_W-1:0] random_word();
        if ($urandom_range(9, 0) == 0) begin
            case ($urandom_range(3, 0))
                0: return 32'sh7fffffff;
                1: return 32'sh80000000;
                2: return '0;
                default: return -32'sd1;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [OP_W-1:0] unused_op();
        case ($urandom_range(2, 0))
            0: return OP_UNUSED_A;
            1: return OP_UNUSED_B;
            default: return OP_UNUSED_C;
        endcase
    endfunction

    // mostly indexes inside the stored words, sometimes anywhere in range
    function automatic logic [INDEX_W-1:0] random_index();
        if (store.shadow_fill > 0 && $urandom_range(99, 0) < 75)
            return INDEX_W'($urandom_range(store.shadow_fill - 1, 0));
        return INDEX_W'($urandom_range(DEPTH - 1, 0));
    endfunction

    // fill phases push hard to reach a full store, drain phases pop and
    // remove down to empty, mixed phases are where clears happen
    task automatic pick_request(input traffic_mode_t mode, output logic [OP_W-1:0] op,
                                output logic [INDEX_W-1:0] idx,
                                output logic signed [VALUE_W-1:0] word);
        int roll;
        roll = $urandom_range(99, 0);
        case (mode)
            MODE_FILL: begin
                if (roll < 84)       op = OP_PUSH;
                else if (roll < 92)  op = OP_READ;
                else if (roll < 95)  op = OP_REMOVE;
                else if (roll < 97)  op = OP_POP;
                else                 op = unused_op();
            end
            MODE_DRAIN: begin
                if (roll < 10)       op = OP_PUSH;
                else if (roll < 40)  op = OP_POP;
                else if (roll < 70)  op = OP_REMOVE;
                else if (roll < 95)  op = OP_READ;
                else                 op = unused_op();
            end
            default: begin
                if (roll < 35)       op = OP_PUSH;
                else if (roll < 50)  op = OP_POP;
                else if (roll < 65)  op = OP_REMOVE;
                else if (roll < 93)  op = OP_READ;
                else if (roll < 96)  op = OP_CLEAR;
                else                 op = unused_op();
            end
        endcase
        idx  = random_index();
        word = random_word();
    endtask

    initial begin
        traffic_mode_t mode;
        int phase_left;
        int burst_left;
        logic [OP_W-1:0] op;
        logic [INDEX_W-1:0] idx;
        logic signed [VALUE_W-1:0] word;

        // synchronous reset, held low from the start
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty store first
        send_request(OP_POP, 6'd0, '0);
        send_request(OP_READ, 6'd0, '0);
        send_request(OP_REMOVE, 6'd0, '0);
        // extreme words
        send_request(OP_PUSH, 6'd63, 32'sh7fffffff);
        send_request(OP_PUSH, 6'd0, 32'sh80000000);
        pause_sender(3);
        send_request(OP_PUSH, 6'd0, '0);
        send_request(OP_PUSH, 6'd0, -32'sd1);
        send_request(OP_PUSH, 6'd0, 32'sh5a5a5a5a);
        send_request(OP_READ, 6'd0, '0);
        send_request(OP_READ, 6'd4, '0);
        // read past the end
        send_request(OP_READ, 6'd63, -32'sd1);
        // remove from the middle closes the gap
        send_request(OP_REMOVE, 6'd1, '0);
        send_request(OP_READ, 6'd1, '0);
        // remove of the last word only drops the count
        send_request(OP_REMOVE, 6'd3, '0);
        send_request(OP_REMOVE, 6'd63, '0);
        send_request(OP_POP, 6'd0, '0);
        // unused op codes leave everything alone
        send_request(OP_UNUSED_A, 6'd63, -32'sd1);
        send_request(OP_UNUSED_B, 6'd0, 32'sh7fffffff);
        send_request(OP_UNUSED_C, 6'd21, 32'sh80000000);
        send_request(OP_CLEAR, 6'd63, -32'sd1);
        send_request(OP_POP, 6'd0, '0);
        // single word removed at the front
        send_request(OP_PUSH, 6'd0, 32'sh12345678);
        send_request(OP_READ, 6'd0, '0);
        send_request(OP_REMOVE, 6'd0, '0);

        // random traffic in phases, sender in bursts with gaps between them
        mode = MODE_FILL;
        phase_left = $urandom_range(120, 90);
        burst_left = $urandom_range(20, 1);
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (phase_left == 0) begin
                case ($urandom_range(9, 0))
                    0, 1, 2, 3: mode = MODE_FILL;
                    4, 5, 6:    mode = MODE_DRAIN;
                    default:    mode = MODE_MIX;
                endcase
                phase_left = (mode == MODE_FILL) ? $urandom_range(120, 60)
                                                 : $urandom_range(80, 30);
            end
            phase_left--;
            pick_request(mode, op, idx, word);
            send_request(op, idx, word);
            burst_left--;
            if (burst_left == 0) begin
                // a third of the bursts run straight into the next one
                if ($urandom_range(2, 0) != 0)
                    pause_sender($urandom_range(10, 1));
                burst_left = $urandom_range(20, 1);
            end
        end
        s_valid <= 1'b0;

        // drain outstanding results, then let the block settle
        while (store.awaited_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("covered %0d requests, %0d results checked, peak fill %0d of %0d",
                 store.requests_seen, store.results_checked, store.peak_fill, DEPTH);
        $display("full pushes %0d, empty pops %0d, misses %0d, shifts %0d, unused %0d",
                 store.full_pushes, store.empty_pops, store.range_misses,
                 store.shifting_removes, store.unused_ops);
        if (store.errors == 0 && store.awaited_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/ivs_pkg.sv
sv/ivs_ram.sv
sv/ivs_ctrl.sv
sv/ivs_datapath.sv
sv/indexed_vector_store.sv
sv/ivs_checker.sv
tb/sv/ivs_tb_pkg.sv
tb/sv/tb_top.sv
